### design/msda_pkg.sv
// Shared constants for the mean and standard deviation accumulator.
// No dependencies; compiled before every other file of the block.
`default_nettype none

package msda_pkg;

    // Fixed widths of the transaction fields.
    localparam int SAMPLE_W    = 20;
    localparam int OUT_W       = 20;
    localparam int COUNT_OUT_W = 7;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_SAMPLES = 64;
    localparam int DEF_VALUE_BITS  = 20;

endpackage

`default_nettype wire

### design/msda_if.sv
// Valid/ready channel interfaces for samples in and statistics out.
// Depends on msda_pkg for the field widths.
`default_nettype none

interface msda_in_if;
    logic                          valid;
    logic                          ready;
    logic [msda_pkg::SAMPLE_W-1:0] sample_value;
    logic                          is_last;

    modport source (output valid, output sample_value, output is_last, input ready);
    modport sink   (input valid, input sample_value, input is_last, output ready);
endinterface

interface msda_out_if;
    logic                             valid;
    logic                             ready;
    logic [msda_pkg::OUT_W-1:0]       mean_value;
    logic [msda_pkg::OUT_W-1:0]       std_dev;
    logic [msda_pkg::COUNT_OUT_W-1:0] sample_count;
    logic                             overflowed;

    modport source (output valid, output mean_value, output std_dev,
                    output sample_count, output overflowed, input ready);
    modport sink   (input valid, input mean_value, input std_dev,
                    input sample_count, input overflowed, output ready);
endinterface

`default_nettype wire

### design/mean_and_std_dev_accumulator.sv
// From a last sample to its result valid the block runs the square steps (none for a sample
// dropped at capacity), a setup step, the n*sumsq and sum*sum multiply steps, the variance
// division, the root steps, the mean division and a publish step; one sample skips variance
// and root. A new sample is taken only once the serial squaring of the previous one is done;
// a sample dropped at capacity leaves the input open.
// Reset (synchronous, active low) clears the statistics, the sequencer and the output valid.
`default_nettype none

module mean_and_std_dev_accumulator #(
    parameter int MAX_SAMPLES = msda_pkg::DEF_MAX_SAMPLES,
    parameter int VALUE_BITS  = msda_pkg::DEF_VALUE_BITS
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    msda_in_if.sink   i_in,
    msda_out_if.source o_out
);
    import msda_pkg::*;

    // Count, sum and sum-of-squares widths follow from the parameters. NW is wide
    // enough for n*sumsq, which bounds every later intermediate value.
    localparam int CW  = $clog2(MAX_SAMPLES + 1);
    localparam int SW  = VALUE_BITS + CW;
    localparam int QW  = 2 * VALUE_BITS + CW;
    localparam int NW  = 2 * VALUE_BITS + 2 * CW;
    localparam int DVW = 2 * CW;
    localparam int CNW = $clog2(NW + 1);

    // The sequencer walks through the accumulate step and the result pass.
    typedef enum logic [2:0] {
        S_IDLE,    // waiting for a sample transaction
        S_SQUARE,  // adding x*x into the sum of squares, one multiplier bit per cycle
        S_PREP,    // start of the result pass
        S_MULN,    // acc = n * sumsq
        S_MULS,    // acc -= sum * sum
        S_DIVV,    // acc = acc / (n*(n-1))
        S_ROOT,    // integer square root of acc
        S_DIVM     // acc = (2*sum + n) / (2*n), then result
    } t_state;

    t_state           r_state,  n_state;
    logic [SW-1:0]    r_sum,    n_sum;
    logic [QW-1:0]    r_sq,     n_sq;
    logic [CW-1:0]    r_count,  n_count;
    logic             r_drop,   n_drop;
    logic             r_last,   n_last;
    logic [NW-1:0]    r_acc,    n_acc;     // product, dividend/quotient, root radicand
    logic [NW-1:0]    r_mcand,  n_mcand;   // shifted multiplicand, later the root
    logic [SW-1:0]    r_mplier, n_mplier;  // multiplier bits, consumed from the LSB
    logic [NW-1:0]    r_bit,    n_bit;     // root trial bit
    logic [DVW-1:0]   r_rem,    n_rem;
    logic [DVW-1:0]   r_div,    n_div;
    logic [CNW-1:0]   r_cnt,    n_cnt;
    logic [OUT_W-1:0] r_sd,     n_sd;
    logic             r_done,   n_done;    // result pass finished, waiting to publish

    logic                   r_out_valid, n_out_valid;
    logic [OUT_W-1:0]       r_out_mean,  n_out_mean;
    logic [OUT_W-1:0]       r_out_sd,    n_out_sd;
    logic [COUNT_OUT_W-1:0] r_out_count, n_out_count;
    logic                   r_out_ovf,   n_out_ovf;

    // The input field is cut or zero-extended to VALUE_BITS.
    logic [VALUE_BITS+SAMPLE_W-1:0] sample_ext;
    logic [VALUE_BITS-1:0]          sample_x;
    logic [CW+COUNT_OUT_W-1:0]      count_ext;
    logic                           in_take;
    logic                           out_free;
    logic [DVW:0]                   div_trial;
    logic                           div_fits;
    logic [NW-1:0]                  root_trial;
    logic                           root_fits;

    assign sample_ext = {{VALUE_BITS{1'b0}}, i_in.sample_value};
    assign sample_x   = sample_ext[VALUE_BITS-1:0];
    assign count_ext  = {{COUNT_OUT_W{1'b0}}, r_count};

    // Samples are taken only in the idle state with no finished result waiting to publish; the
    // result sits in its own register, so a new set can start while it still waits for the sink.
    assign i_in.ready = (r_state == S_IDLE) && !r_done;
    assign in_take    = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;

    // One restoring-division step: bring down the next dividend bit, try the subtract.
    assign div_trial = {r_rem, r_acc[NW-1]};
    assign div_fits  = div_trial >= {1'b0, r_div};

    // One digit-by-digit square-root step.
    assign root_trial = r_mcand + r_bit;
    assign root_fits  = r_acc >= root_trial;

    always_comb begin
        n_state     = r_state;
        n_sum       = r_sum;
        n_sq        = r_sq;
        n_count     = r_count;
        n_drop      = r_drop;
        n_last      = r_last;
        n_acc       = r_acc;
        n_mcand     = r_mcand;
        n_mplier    = r_mplier;
        n_bit       = r_bit;
        n_rem       = r_rem;
        n_div       = r_div;
        n_cnt       = r_cnt;
        n_sd        = r_sd;
        n_done      = r_done;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_mean  = r_out_mean;
        n_out_sd    = r_out_sd;
        n_out_count = r_out_count;
        n_out_ovf   = r_out_ovf;

        unique case (r_state)
            S_IDLE: begin
                if (r_done) begin
                    // Publish the result and clear the statistics for the next set.
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_mean  = r_acc[OUT_W-1:0];
                        n_out_sd    = r_sd;
                        n_out_count = count_ext[COUNT_OUT_W-1:0];
                        n_out_ovf   = r_drop;
                        n_done      = 1'b0;
                        n_sum       = '0;
                        n_sq        = '0;
                        n_count     = '0;
                        n_drop      = 1'b0;
                    end
                end else if (in_take) begin
                    n_last = i_in.is_last;
                    if (r_count < CW'(MAX_SAMPLES)) begin
                        n_sum    = r_sum + SW'(sample_x);
                        n_count  = r_count + CW'(1);
                        n_mcand  = NW'(sample_x);
                        n_mplier = SW'(sample_x);
                        n_cnt    = CNW'(VALUE_BITS - 1);
                        n_state  = S_SQUARE;
                    end else begin
                        // Capacity reached: the sample is dropped but a last mark still counts.
                        n_drop = 1'b1;
                        if (i_in.is_last) begin
                            n_state = S_PREP;
                        end
                    end
                end
            end

            S_SQUARE: begin
                if (r_mplier[0]) begin
                    n_sq = r_sq + r_mcand[QW-1:0];
                end
                n_mcand  = {r_mcand[NW-2:0], 1'b0};
                n_mplier = {1'b0, r_mplier[SW-1:1]};
                n_cnt    = r_cnt - CNW'(1);
                if (r_cnt == '0) begin
                    n_state = r_last ? S_PREP : S_IDLE;
                end
            end

            S_PREP: begin
                if (r_count == '0) begin
                    // No sample in the set: both statistics are zero.
                    n_acc   = '0;
                    n_sd    = '0;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_acc    = '0;
                    n_mcand  = NW'(r_sq);
                    n_mplier = SW'(r_count);
                    n_cnt    = CNW'(CW - 1);
                    n_state  = S_MULN;
                end
            end

            S_MULN: begin
                if (r_mplier[0]) begin
                    n_acc = r_acc + r_mcand;
                end
                n_mcand  = {r_mcand[NW-2:0], 1'b0};
                n_mplier = {1'b0, r_mplier[SW-1:1]};
                n_cnt    = r_cnt - CNW'(1);
                if (r_cnt == '0) begin
                    n_mcand  = NW'(r_sum);
                    n_mplier = r_sum;
                    n_cnt    = CNW'(SW - 1);
                    n_state  = S_MULS;
                end
            end

            S_MULS: begin
                // Partial sums of sum*sum never exceed n*sumsq, so acc stays non-negative.
                if (r_mplier[0]) begin
                    n_acc = r_acc - r_mcand;
                end
                n_mcand  = {r_mcand[NW-2:0], 1'b0};
                n_mplier = {1'b0, r_mplier[SW-1:1]};
                n_cnt    = r_cnt - CNW'(1);
                if (r_cnt == '0) begin
                    n_rem = '0;
                    n_cnt = CNW'(NW - 1);
                    if (r_count > CW'(1)) begin
                        n_div   = DVW'(r_count) * (DVW'(r_count) - DVW'(1));
                        n_state = S_DIVV;
                    end else begin
                        // A single sample has no spread.
                        n_sd    = '0;
                        n_acc   = NW'({r_sum, 1'b0}) + NW'(r_count);
                        n_div   = DVW'({r_count, 1'b0});
                        n_state = S_DIVM;
                    end
                end
            end

            S_DIVV: begin
                n_rem = div_fits ? DVW'(div_trial - {1'b0, r_div}) : div_trial[DVW-1:0];
                n_acc = {r_acc[NW-2:0], div_fits};
                n_cnt = r_cnt - CNW'(1);
                if (r_cnt == '0) begin
                    n_mcand = '0;
                    n_bit   = NW'(1) << (NW - 2);
                    n_cnt   = CNW'(NW / 2 - 1);
                    n_state = S_ROOT;
                end
            end

            S_ROOT: begin
                if (root_fits) begin
                    n_acc   = r_acc - root_trial;
                    n_mcand = {1'b0, r_mcand[NW-1:1]} + r_bit;
                end else begin
                    n_mcand = {1'b0, r_mcand[NW-1:1]};
                end
                n_bit = {2'b00, r_bit[NW-1:2]};
                n_cnt = r_cnt - CNW'(1);
                if (r_cnt == '0) begin
                    n_sd    = n_mcand[OUT_W-1:0];
                    n_acc   = NW'({r_sum, 1'b0}) + NW'(r_count);
                    n_div   = DVW'({r_count, 1'b0});
                    n_rem   = '0;
                    n_cnt   = CNW'(NW - 1);
                    n_state = S_DIVM;
                end
            end

            S_DIVM: begin
                n_rem = div_fits ? DVW'(div_trial - {1'b0, r_div}) : div_trial[DVW-1:0];
                n_acc = {r_acc[NW-2:0], div_fits};
                n_cnt = r_cnt - CNW'(1);
                if (r_cnt == '0) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_sq        <= '0;
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_sq        <= n_sq;
            r_count     <= n_count;
            r_drop      <= n_drop;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
        r_last      <= n_last;
        r_acc       <= n_acc;
        r_mcand     <= n_mcand;
        r_mplier    <= n_mplier;
        r_bit       <= n_bit;
        r_rem       <= n_rem;
        r_div       <= n_div;
        r_cnt       <= n_cnt;
        r_sd        <= n_sd;
        r_out_mean  <= n_out_mean;
        r_out_sd    <= n_out_sd;
        r_out_count <= n_out_count;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.mean_value   = r_out_mean;
    assign o_out.std_dev      = r_out_sd;
    assign o_out.sample_count = r_out_count;
    assign o_out.overflowed   = r_out_ovf;

endmodule

`default_nettype wire

### design/msda_chk.sv
// Port-level checker for the mean and standard deviation accumulator, bound to the top.
// Depends on msda_pkg for field widths and on mean_and_std_dev_accumulator.
`default_nettype none

module msda_chk #(
    parameter int MAX_SAMPLES = msda_pkg::DEF_MAX_SAMPLES
) (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire                             i_in_valid,
    input wire                             i_in_ready,
    input wire                             i_in_is_last,
    input wire                             i_out_valid,
    input wire                             i_out_ready,
    input wire [msda_pkg::OUT_W-1:0]       i_out_mean,
    input wire [msda_pkg::OUT_W-1:0]       i_out_sd,
    input wire [msda_pkg::COUNT_OUT_W-1:0] i_out_count
);
    import msda_pkg::*;

    // A result transaction waits until the sink takes it.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_mean)
            && $stable(i_out_sd) && $stable(i_out_count))
        else $error("result dropped or changed while stalled");

    // The result pass keeps the input closed on the cycle after a last sample.
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_is_last |=> !i_in_ready)
        else $error("sample taken right after a last sample");

    // Every published set holds at least one sample.
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (MAX_SAMPLES >= 128) || (i_out_count != '0))
        else $error("result with zero samples");

    // One sample has no spread.
    a_single_no_spread: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_count == COUNT_OUT_W'(1))
            |-> (MAX_SAMPLES >= 128) || (i_out_sd == '0))
        else $error("nonzero deviation for a single sample");

    // No result appears straight out of reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind mean_and_std_dev_accumulator msda_chk #(
    .MAX_SAMPLES (MAX_SAMPLES)
) u_msda_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_is_last (i_in.is_last),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_mean   (o_out.mean_value),
    .i_out_sd     (o_out.std_dev),
    .i_out_count  (o_out.sample_count)
);

`default_nettype wire

### test/msda_stats_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the mean and standard deviation accumulator: watches both channels,
// predicts each set's statistics and compares them. Depends on msda_pkg and msda_if.

module msda_stats_checker #(
    parameter int MAX_SAMPLES = msda_pkg::DEF_MAX_SAMPLES,
    parameter int VALUE_BITS  = msda_pkg::DEF_VALUE_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    msda_in_if   i_in_mon,
    msda_out_if  i_out_mon,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_results
);
    import msda_pkg::*;

    typedef struct packed {
        logic [OUT_W-1:0]       mean_value;
        logic [OUT_W-1:0]       std_dev;
        logic [COUNT_OUT_W-1:0] sample_count;
        logic                   overflowed;
    } t_stats;

    // Statistics of sets already closed, oldest first.
    t_stats pending_stats[$];

    // Running statistics of the set in progress.
    logic [63:0] sum_acc;
    logic [63:0] sq_sum_acc;
    logic [63:0] count_acc;
    logic        drop_seen;

    int fails   = 0;
    int results = 0;

    // Floor of the square root, one result bit per step from the top down.
    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0]  root;
        logic [63:0]  trial;
        logic [127:0] square;
        int           b;
        root = '0;
        for (b = 31; b >= 0; b--) begin
            trial  = root | (64'd1 << b);
            square = trial * trial;
            if (square <= {64'd0, v}) begin
                root = trial;
            end
        end
        return root;
    endfunction

    function automatic t_stats finish_statistics();
        t_stats      s;
        logic [63:0] n;
        logic [63:0] mean;
        logic [63:0] sd;
        logic [63:0] num;
        logic [63:0] den;
        n    = count_acc;
        mean = '0;
        sd   = '0;
        if (n != 0) begin
            mean = (64'd2 * sum_acc + n) / (64'd2 * n);
        end
        if (n > 1) begin
            num = n * sq_sum_acc - sum_acc * sum_acc;
            den = n * (n - 64'd1);
            sd  = root_floor(num / den);
        end
        s.mean_value   = mean[OUT_W-1:0];
        s.std_dev      = sd[OUT_W-1:0];
        s.sample_count = n[COUNT_OUT_W-1:0];
        s.overflowed   = drop_seen;
        return s;
    endfunction

    task automatic add_sample(input logic [SAMPLE_W-1:0] value);
        logic [63:0] x;
        x = 64'(value) & ((64'd1 << VALUE_BITS) - 64'd1);
        if (count_acc < MAX_SAMPLES) begin
            sum_acc    = sum_acc + x;
            sq_sum_acc = sq_sum_acc + x * x;
            count_acc  = count_acc + 64'd1;
        end else begin
            drop_seen = 1'b1;
        end
    endtask

    task automatic clear_statistics();
        sum_acc    = '0;
        sq_sum_acc = '0;
        count_acc  = '0;
        drop_seen  = 1'b0;
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            fails++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_stats got;
        t_stats want;
        if (!i_rst_n) begin
            clear_statistics();
            pending_stats.delete();
        end else begin
            // Results are matched before this edge's sample is taken, so a stray result
            // can never pair with an expectation created in the same cycle.
            if (i_out_mon.valid && i_out_mon.ready) begin
                got.mean_value   = i_out_mon.mean_value;
                got.std_dev      = i_out_mon.std_dev;
                got.sample_count = i_out_mon.sample_count;
                got.overflowed   = i_out_mon.overflowed;
                if (pending_stats.size() == 0) begin
                    fails++;
                    $display({"%0t: unexpected result: expected none, actual mean %0d",
                              " sd %0d count %0d overflowed %0d"},
                             $time, got.mean_value, got.std_dev, got.sample_count,
                             got.overflowed);
                end else begin
                    want = pending_stats.pop_front();
                    check_field("mean_value", 32'(want.mean_value), 32'(got.mean_value));
                    check_field("std_dev", 32'(want.std_dev), 32'(got.std_dev));
                    check_field("sample_count", 32'(want.sample_count),
                                32'(got.sample_count));
                    check_field("overflowed", 32'(want.overflowed), 32'(got.overflowed));
                    results++;
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                add_sample(i_in_mon.sample_value);
                if (i_in_mon.is_last) begin
                    pending_stats.push_back(finish_statistics());
                    clear_statistics();
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= pending_stats.size();
        o_results    <= results;
    end

endmodule

### test/tb_mean_and_std_dev_accumulator.sv
`timescale 1ns / 1ps
// Top of the testbench for mean_and_std_dev_accumulator: clock, reset, sample stimulus,
// result back-pressure and verdict. Depends on msda_pkg, msda_if and msda_stats_checker.

module tb_mean_and_std_dev_accumulator;
    import msda_pkg::*;

    localparam int MAX_SAMPLES    = DEF_MAX_SAMPLES;
    localparam int VALUE_BITS     = DEF_VALUE_BITS;
    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 12;
    localparam int TARGET_SAMPLES = 1150;
    // The receiver's long hold-off is triggered once this many results have come back.
    localparam int HOLD_AFTER     = 8;
    localparam int LONG_HOLD      = 800;
    // A set's result pass runs the two multiplies, the two divisions and the root steps.
    // The drain covers it with margin.
    localparam int DRAIN_CYCLES   = 300;
    // Longest correct stretch with no transaction on either channel: the long hold-off
    // plus one result pass plus a sender gap. The limit takes
    // that several times over.
    localparam int IDLE_LIMIT     = 5000;

    localparam logic [SAMPLE_W-1:0] FULL_SCALE = '1;

    // How the values inside one random set are drawn.
    typedef enum int {
        SPREAD_FULL,
        SPREAD_NEAR,
        SPREAD_RAILS,
        SPREAD_TINY,
        SPREAD_TOP
    } t_spread;

    // Patterns for the result receiver's ready.
    typedef enum int {
        ALWAYS_READY,
        COIN_FLIP,
        MOSTLY_STALLED,
        CADENCE
    } t_stall;

    logic i_clk;
    logic i_rst_n;

    msda_in_if  in_ch ();
    msda_out_if out_ch ();

    int fail_count;
    int pending;
    int results_seen;

    int burst_left;
    int samples_sent;
    int sets_sent;
    int overfull_sets;
    int quiet_cycles;
    bit long_hold_done;

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    mean_and_std_dev_accumulator #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .VALUE_BITS  (VALUE_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // The scoreboard sits beside the block and only watches the two channels.
    msda_stats_checker #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .VALUE_BITS  (VALUE_BITS)
    ) stats_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results_seen)
    );

    // Offers one sample and returns in the time step of the edge that accepted it, so
    // the next call can replace the payload without dropping valid. The sender works in
    // bursts: when a burst runs out it may pause for a random gap before the next one.
    task automatic offer_sample(input logic [SAMPLE_W-1:0] value, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        in_ch.valid        <= 1'b1;
        in_ch.sample_value <= value;
        in_ch.is_last      <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        burst_left--;
        samples_sent++;
    endtask

    // Holds the sender off until every closed set has produced its result. The
    // scoreboard's count is registered, so the first look comes at the next edge.
    task automatic wait_results_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Most sets are short so that results come often; a fair share sits around the
    // capacity so that the drop path and the exact-capacity case are both hit.
    function automatic int pick_set_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 8);
        end else if (r < 88) begin
            return $urandom_range(9, 40);
        end
        return $urandom_range(MAX_SAMPLES - 4, MAX_SAMPLES + 8);
    endfunction

    task automatic send_set(input int len, input t_spread spread);
        logic [SAMPLE_W-1:0] base;
        logic [SAMPLE_W-1:0] value;
        int                  spread_bits;
        int                  i;
        base        = SAMPLE_W'($urandom);
        spread_bits = $urandom_range(0, 12);
        for (i = 0; i < len; i++) begin
            case (spread)
                SPREAD_FULL:  value = SAMPLE_W'($urandom);
                // Clustered values give a small variance on a large mean.
                SPREAD_NEAR:  value = base ^ (SAMPLE_W'($urandom) &
                                              SAMPLE_W'((1 << spread_bits) - 1));
                SPREAD_RAILS: value = ($urandom_range(0, 1) == 1) ? FULL_SCALE : '0;
                SPREAD_TOP:   value = FULL_SCALE;
                default:      value = SAMPLE_W'($urandom_range(0, 15));
            endcase
            offer_sample(value, i == len - 1);
        end
        sets_sent++;
        if (len > MAX_SAMPLES) begin
            overfull_sets++;
        end
    endtask

    // Result receiver. It runs segments of random length, each with its own ready
    // pattern, and once a handful of results have come it holds ready low for a long
    // stretch while the sender keeps going, so the block backs up and stalls its input.
    initial begin
        t_stall mode;
        int     seg_len;
        int     phase;
        out_ch.ready   <= 1'b0;
        long_hold_done = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!long_hold_done && results_seen >= HOLD_AFTER) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_done = 1'b1;
            end
            mode    = t_stall'($urandom_range(0, 3));
            seg_len = $urandom_range(16, 160);
            phase   = 0;
            repeat (seg_len) begin
                case (mode)
                    ALWAYS_READY:   out_ch.ready <= 1'b1;
                    COIN_FLIP:      out_ch.ready <= 1'($urandom_range(0, 1));
                    MOSTLY_STALLED: out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:        out_ch.ready <= ((phase % 7) < 4);
                endcase
                phase++;
                @(posedge i_clk);
            end
        end
    end

    // Watchdog: ends the run if neither channel completes a transaction for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("mean_and_std_dev_accumulator verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus and verdict.
    initial begin
        int      set_idx;
        int      len;
        t_spread spread;
        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.sample_value <= '0;
        in_ch.is_last      <= 1'b0;
        burst_left         = 0;
        samples_sent       = 0;
        sets_sent          = 0;
        overfull_sets      = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed sets. A single sample at each rail gives a zero deviation.
        offer_sample(FULL_SCALE, 1'b1);
        offer_sample('0, 1'b1);
        // Both rails in one pair: the largest deviation a pair can have.
        offer_sample('0, 1'b0);
        offer_sample(FULL_SCALE, 1'b1);
        // Largest sum of squares per sample with no spread at all.
        offer_sample(FULL_SCALE, 1'b0);
        offer_sample(FULL_SCALE, 1'b1);
        // A mean of exactly one and a half must round up.
        offer_sample(20'd1, 1'b0);
        offer_sample(20'd2, 1'b1);
        // A mean whose fraction is below a half must round down; the variance truncates too.
        offer_sample(20'd1, 1'b0);
        offer_sample(20'd2, 1'b0);
        offer_sample(20'd4, 1'b1);
        // Alternating bit patterns so every sample bit is driven both ways early on.
        offer_sample(20'hAAAAA, 1'b0);
        offer_sample(20'h55555, 1'b0);
        offer_sample(FULL_SCALE, 1'b0);
        offer_sample(20'h00001, 1'b1);
        sets_sent = 7;
        wait_results_drained();

        // Random sets. The first three pin the capacity cases: exactly full, one sample
        // dropped with the last one among the dropped, and a full-scale overfull set
        // that pushes the running sum to its largest value.
        set_idx = 0;
        while (samples_sent < TARGET_SAMPLES) begin
            if (set_idx == 0) begin
                len    = MAX_SAMPLES;
                spread = SPREAD_FULL;
            end else if (set_idx == 1) begin
                len    = MAX_SAMPLES + 1;
                spread = SPREAD_RAILS;
            end else if (set_idx == 2) begin
                len    = MAX_SAMPLES + 8;
                spread = SPREAD_TOP;
            end else begin
                len    = pick_set_length();
                spread = t_spread'($urandom_range(0, 4));
            end
            send_set(len, spread);
            // Now and then the sender stops until the pipeline is empty.
            if (set_idx % 25 == 24) begin
                wait_results_drained();
            end
            set_idx++;
        end

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d samples in %0d sets, %0d of them past capacity.",
                 samples_sent, sets_sent, overfull_sets);
        $display("Compared %0d results field by field against the predicted statistics.",
                 results_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("mean_and_std_dev_accumulator verification clean");
        end else begin
            $display("mean_and_std_dev_accumulator verification failed");
        end
        $finish;
    end

endmodule
